FILE: src/afd_pkg.sv
// Package for the API frame deframer: register indexes, reset values and field widths.
// No dependencies; used by api_frame_deframer and its checker.
`timescale 1ns / 1ps
`default_nettype none
package afd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LengthWidth = 16;
   localparam int unsigned CsrIdxWidth = 1;
   localparam int unsigned CsrDatWidth = 16;

   localparam logic [CsrIdxWidth-1:0] CSR_START_DELIMITER  = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_FRAME_LENGTH = 1'd1;

   localparam logic [ByteWidth-1:0]   START_DELIMITER_RESET  = 8'd126;
   localparam logic [LengthWidth-1:0] MAX_FRAME_LENGTH_RESET = 16'd256;

endpackage
`default_nettype wire

FILE: src/api_frame_deframer.sv
// API frame deframer: hunts for the delimiter, reads the 16-bit length, passes on data and checksum.
// Depends on afd_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One received byte is taken per cycle on req_; each data byte and the closing checksum byte
// leave on rsp_ in the next cycle from a single output register. Delimiter and length bytes give
// no transaction on rsp_. A byte is taken whenever the output register is empty or is being
// emptied in the same cycle, so with rsp_ready held high the block sustains one byte per cycle.
// The checksum is passed on unchecked; a zero length goes straight to the checksum byte.
// Data bytes whose index reaches max_frame_length are flagged with rsp_overflow.
module api_frame_deframer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [afd_pkg::ByteWidth-1:0]      req_rx_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [afd_pkg::ByteWidth-1:0]           rsp_data_byte,
   output logic [afd_pkg::LengthWidth-1:0]         rsp_byte_position,
   output logic [afd_pkg::LengthWidth-1:0]         rsp_frame_length,
   output logic                                    rsp_frame_end,
   output logic                                    rsp_overflow,
   input  wire logic                               csr_we,
   input  wire logic [afd_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [afd_pkg::CsrDatWidth-1:0]    csr_wdata
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN,
      PH_DATA,
      PH_CSUM
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic                               len_cnt_ff, len_cnt_in;
   logic [afd_pkg::ByteWidth-1:0]      len_hi_ff, len_hi_in;
   logic [afd_pkg::LengthWidth-1:0]    decl_len_ff, decl_len_in;
   logic [afd_pkg::LengthWidth-1:0]    data_idx_ff, data_idx_in;
   logic [afd_pkg::ByteWidth-1:0]      delim_ff;
   logic [afd_pkg::LengthWidth-1:0]    max_len_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [afd_pkg::ByteWidth-1:0]      rsp_byte_ff, rsp_byte_in;
   logic [afd_pkg::LengthWidth-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [afd_pkg::LengthWidth-1:0]    rsp_len_ff, rsp_len_in;
   logic                               rsp_end_ff, rsp_end_in;
   logic                               rsp_ovf_ff, rsp_ovf_in;

   logic                               accept;
   logic                               produce;
   logic [afd_pkg::LengthWidth-1:0]    full_len;
   logic [afd_pkg::LengthWidth-1:0]    idx_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full_len  = {len_hi_ff, req_rx_byte};
   assign idx_next  = data_idx_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      len_cnt_in  = len_cnt_ff;
      len_hi_in   = len_hi_ff;
      decl_len_in = decl_len_ff;
      data_idx_in = data_idx_ff;
      produce     = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == delim_ff) begin
                  phase_in   = PH_LEN;
                  len_cnt_in = 1'b0;
               end
            end
            PH_LEN: begin
               if (!len_cnt_ff) begin
                  len_hi_in  = req_rx_byte;
                  len_cnt_in = 1'b1;
               end else begin
                  decl_len_in = full_len;
                  len_cnt_in  = 1'b0;
                  data_idx_in = '0;
                  phase_in    = (full_len == '0) ? PH_CSUM : PH_DATA;
               end
            end
            PH_DATA: begin
               produce     = 1'b1;
               rsp_byte_in = req_rx_byte;
               rsp_pos_in  = data_idx_ff;
               rsp_len_in  = decl_len_ff;
               rsp_end_in  = 1'b0;
               rsp_ovf_in  = (data_idx_ff >= max_len_ff);
               if ((idx_next >= decl_len_ff) || (idx_next == '0)) begin
                  data_idx_in = '0;
                  phase_in    = PH_CSUM;
               end else begin
                  data_idx_in = idx_next;
               end
            end
            PH_CSUM: begin
               produce     = 1'b1;
               rsp_byte_in = req_rx_byte;
               rsp_pos_in  = '0;
               rsp_len_in  = decl_len_ff;
               rsp_end_in  = 1'b1;
               rsp_ovf_in  = 1'b0;
               phase_in    = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
      rsp_valid_in = produce || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         len_cnt_ff   <= 1'b0;
         len_hi_ff    <= '0;
         decl_len_ff  <= '0;
         data_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         delim_ff     <= afd_pkg::START_DELIMITER_RESET;
         max_len_ff   <= afd_pkg::MAX_FRAME_LENGTH_RESET;
      end else begin
         phase_ff     <= phase_in;
         len_cnt_ff   <= len_cnt_in;
         len_hi_ff    <= len_hi_in;
         decl_len_ff  <= decl_len_in;
         data_idx_ff  <= data_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               afd_pkg::CSR_START_DELIMITER:
                  delim_ff <= csr_wdata[afd_pkg::ByteWidth-1:0];
               afd_pkg::CSR_MAX_FRAME_LENGTH:
                  max_len_ff <= csr_wdata[afd_pkg::LengthWidth-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_byte_ff;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_frame_length  = rsp_len_ff;
   assign rsp_frame_end     = rsp_end_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule
`default_nettype wire

FILE: src/afd_checker.sv
// Port-level checker for api_frame_deframer, with the bind that attaches it.
// Depends on afd_pkg and api_frame_deframer.
`timescale 1ns / 1ps
`default_nettype none
module afd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [afd_pkg::ByteWidth-1:0]    rsp_data_byte,
   input wire logic [afd_pkg::LengthWidth-1:0]  rsp_byte_position,
   input wire logic [afd_pkg::LengthWidth-1:0]  rsp_frame_length,
   input wire logic                             rsp_frame_end,
   input wire logic                             rsp_overflow
);

   // Stalled output transaction holds its data byte, position and end flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_byte_position) && $stable(rsp_frame_end))
      else $error("rsp payload changed while stalled");

   // Checksum transaction carries position 0 and no overflow
   a_csum_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_byte_position == '0 && !rsp_overflow)
      else $error("checksum transaction with bad fields");

   // Data byte index lies inside the declared length
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_byte_position < rsp_frame_length)
      else $error("data position beyond declared length");

   // Input side stalls exactly when the output register is full and stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready inconsistent with output register");

endmodule

bind api_frame_deframer afd_checker u_afd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_byte_position (rsp_byte_position),
   .rsp_frame_length  (rsp_frame_length),
   .rsp_frame_end     (rsp_frame_end),
   .rsp_overflow      (rsp_overflow)
);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for api_frame_deframer: byte stream in, data and checksum out.
// Depends on afd_pkg and api_frame_deframer; keeps its own deframer model for the expected output.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   typedef enum logic [1:0] {
      RX_HUNT,
      RX_LENGTH,
      RX_DATA,
      RX_CHECKSUM
   } rx_phase_type;

   typedef struct packed {
      logic [afd_pkg::ByteWidth-1:0]   data_byte;
      logic [afd_pkg::LengthWidth-1:0] byte_position;
      logic [afd_pkg::LengthWidth-1:0] frame_length;
      logic                            frame_end;
      logic                            overflow;
   } deframed_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [afd_pkg::ByteWidth-1:0]   req_rx_byte;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [afd_pkg::ByteWidth-1:0]   rsp_data_byte;
   logic [afd_pkg::LengthWidth-1:0] rsp_byte_position;
   logic [afd_pkg::LengthWidth-1:0] rsp_frame_length;
   logic                            rsp_frame_end;
   logic                            rsp_overflow;
   logic                            csr_we;
   logic [afd_pkg::CsrIdxWidth-1:0] csr_index;
   logic [afd_pkg::CsrDatWidth-1:0] csr_wdata;

   api_frame_deframer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_overflow      (rsp_overflow),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // model state and register copies
   rx_phase_type                    rx_phase;
   logic [afd_pkg::ByteWidth-1:0]   len_high;
   logic                            len_count;
   logic [afd_pkg::LengthWidth-1:0] decl_len;
   logic [afd_pkg::LengthWidth-1:0] data_idx;
   logic [afd_pkg::ByteWidth-1:0]   cfg_delimiter;
   logic [afd_pkg::LengthWidth-1:0] cfg_max_len;

   deframed_type deframed_q[$];

   bit sender_idling;
   bit receiver_idling;
   int stall_left;
   int bytes_sent;
   int results_checked;
   int frames_seen;
   int overflows_seen;
   int settings_used;
   int mismatches;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #5ms;
      $display("api_frame_deframer test failed");
      $finish;
   end

   function automatic void deframe_byte(input logic [afd_pkg::ByteWidth-1:0] b);
      deframed_type r;
      case (rx_phase)
         RX_HUNT: begin
            if (b == cfg_delimiter) begin
               rx_phase  = RX_LENGTH;
               len_count = 1'b0;
            end
         end
         RX_LENGTH: begin
            if (!len_count) begin
               len_high  = b;
               len_count = 1'b1;
            end else begin
               decl_len  = {len_high, b};
               len_count = 1'b0;
               data_idx  = '0;
               rx_phase  = (decl_len == '0) ? RX_CHECKSUM : RX_DATA;
            end
         end
         RX_DATA: begin
            r.data_byte     = b;
            r.byte_position = data_idx;
            r.frame_length  = decl_len;
            r.frame_end     = 1'b0;
            r.overflow      = (data_idx >= cfg_max_len);
            deframed_q.push_back(r);
            data_idx = data_idx + 16'd1;
            if (data_idx >= decl_len || data_idx == '0) begin
               data_idx = '0;
               rx_phase = RX_CHECKSUM;
            end
         end
         default: begin
            r.data_byte     = b;
            r.byte_position = '0;
            r.frame_length  = decl_len;
            r.frame_end     = 1'b1;
            r.overflow      = 1'b0;
            deframed_q.push_back(r);
            rx_phase = RX_HUNT;
         end
      endcase
   endfunction

   // result checking and receiver stalls
   always @(posedge clock) begin
      deframed_type want;
      deframed_type got;
      got.data_byte     = rsp_data_byte;
      got.byte_position = rsp_byte_position;
      got.frame_length  = rsp_frame_length;
      got.frame_end     = rsp_frame_end;
      got.overflow      = rsp_overflow;
      if (!reset && rsp_valid && rsp_ready) begin
         if (deframed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected transaction byte=%h pos=%0d len=%0d end=%b ovf=%b",
                        $realtime, got.data_byte, got.byte_position, got.frame_length,
                        got.frame_end, got.overflow);
         end else begin
            want = deframed_q.pop_front();
            results_checked++;
            if (want.frame_end) frames_seen++;
            if (want.overflow) overflows_seen++;
            if (got.data_byte !== want.data_byte || got.byte_position !== want.byte_position ||
                got.frame_length !== want.frame_length || got.frame_end !== want.frame_end ||
                got.overflow !== want.overflow) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: mismatch exp byte=%h pos=%0d len=%0d end=%b ovf=%b",
                           $realtime, want.data_byte, want.byte_position, want.frame_length,
                           want.frame_end, want.overflow);
                  $display("%0t:          got byte=%h pos=%0d len=%0d end=%b ovf=%b",
                           $realtime, got.data_byte, got.byte_position, got.frame_length,
                           got.frame_end, got.overflow);
               end
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [afd_pkg::ByteWidth-1:0] b);
      int gap;
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deframe_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [afd_pkg::CsrIdxWidth-1:0] idx,
                            input logic [afd_pkg::CsrDatWidth-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == afd_pkg::CSR_START_DELIMITER)
         cfg_delimiter = value[afd_pkg::ByteWidth-1:0];
      else
         cfg_max_len = value;
      settings_used++;
   endtask

   task automatic configure(input logic [afd_pkg::ByteWidth-1:0] delim,
                            input logic [afd_pkg::LengthWidth-1:0] max_len);
      write_csr(afd_pkg::CSR_START_DELIMITER, {8'd0, delim});
      write_csr(afd_pkg::CSR_MAX_FRAME_LENGTH, max_len);
   endtask

   function automatic logic [afd_pkg::ByteWidth-1:0] noise_byte();
      logic [afd_pkg::ByteWidth-1:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == cfg_delimiter);
      return b;
   endfunction

   task automatic send_frame(input int len);
      int noise;
      logic [afd_pkg::ByteWidth-1:0] b;
      noise = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (noise) send_byte(noise_byte());
      send_byte(cfg_delimiter);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      repeat (len) begin
         b = ($urandom_range(0, 15) == 0) ? cfg_delimiter : 8'($urandom_range(0, 255));
         send_byte(b);
      end
      send_byte(8'($urandom_range(0, 255)));
   endtask

   // truncated frame, then stray bytes until the deframer is hunting again
   task automatic send_broken_frame();
      int len;
      int cut;
      len = $urandom_range(2, 12);
      cut = $urandom_range(0, len - 1);
      send_byte(cfg_delimiter);
      send_byte(8'd0);
      send_byte(8'(len));
      repeat (cut) send_byte(8'($urandom_range(0, 255)));
      while (rx_phase != RX_HUNT) send_byte(noise_byte());
   endtask

   task automatic run_traffic(input int budget);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         case ($urandom_range(0, 9))
            0:       send_broken_frame();
            1:       send_frame($urandom_range(0, 3));
            default: send_frame($urandom_range(1, 24));
         endcase
      end
   endtask

   task automatic test_directed_frames();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(0);
      send_byte(cfg_delimiter);
      send_byte(8'h00);
      send_byte(8'h03);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(cfg_delimiter);
      send_byte(8'hA5);
      write_csr(afd_pkg::CSR_MAX_FRAME_LENGTH, 16'd2);
      send_byte(cfg_delimiter);
      send_byte(8'h00);
      send_byte(8'h04);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(8'h44);
      send_byte(8'hC3);
   endtask

   task automatic test_default_settings();
      configure(afd_pkg::START_DELIMITER_RESET, afd_pkg::MAX_FRAME_LENGTH_RESET);
      run_traffic(150);
      send_frame(270);
   endtask

   task automatic test_delimiter_extremes();
      configure(8'd0, 16'd1);
      run_traffic(150);
      configure(8'd255, 16'hFFFF);
      run_traffic(150);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         configure(8'($urandom_range(0, 255)), 16'($urandom_range(1, 16)));
         run_traffic(60);
      end
   endtask

   task automatic test_zero_max_length();
      write_csr(afd_pkg::CSR_MAX_FRAME_LENGTH, 16'd0);
      run_traffic(80);
   endtask

   task automatic test_drain_pauses();
      configure(afd_pkg::START_DELIMITER_RESET, 16'd12);
      repeat (6) begin
         send_frame($urandom_range(1, 20));
         wait_idle();
      end
   endtask

   task automatic test_back_to_back();
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      configure(afd_pkg::START_DELIMITER_RESET, 16'd8);
      run_traffic(250);
   endtask

   initial begin
      rx_phase        = RX_HUNT;
      len_high        = '0;
      len_count       = 1'b0;
      decl_len        = '0;
      data_idx        = '0;
      cfg_delimiter   = afd_pkg::START_DELIMITER_RESET;
      cfg_max_len     = afd_pkg::MAX_FRAME_LENGTH_RESET;
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      stall_left      = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      rsp_ready   <= 1'b0;
      csr_we      <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_default_settings();
      test_delimiter_extremes();
      test_random_settings();
      test_zero_max_length();
      test_drain_pauses();
      test_back_to_back();

      wait_idle();
      repeat (8) @(posedge clock);
      if (deframed_q.size() != 0) mismatches++;
      $display("Fed %0d bytes across %0d register writes and checked %0d transactions,",
               bytes_sent, settings_used, results_checked);
      $display("covering %0d complete frames with %0d data bytes flagged as overflow.",
               frames_seen, overflows_seen);
      if (mismatches == 0)
         $display("api_frame_deframer test passed");
      else
         $display("api_frame_deframer test failed");
      $finish;
   end

endmodule
`default_nettype wire
